>>> design/cgbl_pkg.sv
// ----------------------------------------------------------------------------
// Cost grid bilinear lookup: shared package
// Field widths, register indexes, operation codes, sequencer states and the
// control bundle of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package cgbl_pkg;

  // Payload field widths.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned COST_W     = 24;
  localparam int unsigned POS_W      = 18;
  localparam int unsigned RES_W      = 32;

  // Configuration register widths.
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned MARGIN_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Fixed-point format of query positions and of the result.
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned OUT_FRAC   = 8;

  // Default store edge length in cells.
  localparam int unsigned MAX_DIM_DEF = 256;

  // Multiply-accumulate unit widths.
  localparam int unsigned MAC_A_W = COST_W + FRAC_BITS;
  localparam int unsigned MAC_B_W = SCALE_W;
  localparam int unsigned ACC_W   = COST_W + 2 * FRAC_BITS + SCALE_W + 1;
  localparam int unsigned MAC_SH  = 2 * FRAC_BITS;

  // Register reset values.
  localparam logic [DIM_W-1:0]    GRID_WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0]    GRID_HEIGHT_RST = DIM_W'(256);
  localparam logic [SCALE_W-1:0]  COST_SCALE_RST  = SCALE_W'(65535);
  localparam logic [MARGIN_W-1:0] MARGIN_RST      = '0;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_GRID_HEIGHT  = 2'd1,
    REG_COST_SCALE   = 2'd2,
    REG_MARGIN_CELLS = 2'd3
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRITE = 5'b00010,
    S_FILL  = 5'b00100,
    S_QUERY = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;     // update the accumulator
    logic clr;    // load the product instead of adding it
    logic shift;  // weight the product by 2^MAC_SH
  } mac_ctrl_t;

endpackage

>>> design/cgbl_in_if.sv
// ----------------------------------------------------------------------------
// Cost grid bilinear lookup: input channel
// Valid/ready channel that carries one operation item.
// ----------------------------------------------------------------------------
interface cgbl_in_if import cgbl_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [COORD_W-1:0]      cell_x;
  logic [COORD_W-1:0]      cell_y;
  logic [COST_W-1:0]       cost_value;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;

  modport source (
    output valid, operation, cell_x, cell_y, cost_value, pos_x, pos_y,
    input  ready
  );

  modport sink (
    input  valid, operation, cell_x, cell_y, cost_value, pos_x, pos_y,
    output ready
  );

endinterface

>>> design/cgbl_out_if.sv
// ----------------------------------------------------------------------------
// Cost grid bilinear lookup: result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface cgbl_out_if import cgbl_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [RES_W-1:0]   cost_to_go;
  logic               inside_margin;
  logic [COST_W-1:0]  max_cost;
  logic               status;

  modport source (
    output valid, cost_to_go, inside_margin, max_cost, status,
    input  ready
  );

  modport sink (
    input  valid, cost_to_go, inside_margin, max_cost, status,
    output ready
  );

endinterface

>>> design/cgbl_store.sv
// ----------------------------------------------------------------------------
// Cost grid bilinear lookup: cost store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module cgbl_store #(
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 24
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/cgbl_mac.sv
// ----------------------------------------------------------------------------
// Cost grid bilinear lookup: multiply-accumulate unit
// One unsigned multiplier feeding an accumulator; shared by every
// interpolation and scaling step of a query.
// ----------------------------------------------------------------------------
module cgbl_mac import cgbl_pkg::*; (
  input  logic               clk_i,
  input  mac_ctrl_t          ctrl_i,
  input  logic [MAC_A_W-1:0] a_i,
  input  logic [MAC_B_W-1:0] b_i,
  output logic [ACC_W-1:0]   acc_o
);

  logic [MAC_A_W+MAC_B_W-1:0] prod;
  logic [ACC_W-1:0]           addend;
  logic [ACC_W-1:0]           acc_q;

  // Product, optionally moved up to the weight of the high part.
  always_comb begin
    prod   = a_i * b_i;
    addend = ctrl_i.shift ? (ACC_W'(prod) << MAC_SH) : ACC_W'(prod);
  end

  // Accumulator: load or add.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= ctrl_i.clr ? addend : acc_q + addend;
    end
  end

  assign acc_o = acc_q;

endmodule

>>> design/cost_grid_bilinear_lookup_top.sv
// ----------------------------------------------------------------------------
// Cost grid bilinear lookup: top level
// Grid of cost-to-go values with a running maximum. Write sets one cell,
// fill sets every cell, query interpolates four neighbors bilinearly and
// scales the result to meters.
//
//   Channel   Direction  Handshake      Contents
//   in_ch_i   input      valid/ready    operation, cell, cost, position
//   out_ch_o  output     valid/ready    cost_to_go, margin, maximum, status
//   cfg_*     input      write enable   register index and data
//
// A query makes four reads through the single read port of the store that
// overlap eight passes through the shared multiply-accumulate unit, then
// one rounding step. A fill writes one store entry per cycle over all
// 2**(2*clog2(MAX_DIM)) entries. Every operation ends in the result state,
// stretched while a result still waits in the output register. Reset
// clears the maximum and the registers, not the store.
// ----------------------------------------------------------------------------
module cost_grid_bilinear_lookup_top import cgbl_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cgbl_in_if.sink               in_ch_i,
  cgbl_out_if.source            out_ch_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned DIM_BITS = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W   = 2 * DIM_BITS;
  // Cell coordinates carry a sign bit and room for one step past the edge.
  localparam int unsigned CELL_W   = POS_W - FRAC_BITS;
  localparam int unsigned CW       = CELL_W + 1;
  localparam int unsigned MW       = CW + 1;
  localparam int unsigned WT_W     = FRAC_BITS + 1;
  localparam logic [WT_W-1:0]      ONE     = WT_W'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] HALF    = FRAC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [CW-1:0]        DIM_MAX = CW'(MAX_DIM);
  localparam int unsigned RND_SH   = 2 * FRAC_BITS + SCALE_W - OUT_FRAC;
  localparam int unsigned SUM_W    = ACC_W + 1;
  localparam int unsigned RND_W    = SUM_W - RND_SH;
  localparam logic [SUM_W-1:0]     RND_BIAS = SUM_W'(1) << (RND_SH - 1);

  // Query sequencer steps.
  localparam logic [3:0] ST_RD0   = 4'd0;
  localparam logic [3:0] ST_RD1   = 4'd1;
  localparam logic [3:0] ST_RD2   = 4'd2;
  localparam logic [3:0] ST_RD3   = 4'd3;
  localparam logic [3:0] ST_ROW1  = 4'd4;
  localparam logic [3:0] ST_COL0  = 4'd5;
  localparam logic [3:0] ST_COL1  = 4'd6;
  localparam logic [3:0] ST_SCLH  = 4'd7;
  localparam logic [3:0] ST_SCLL  = 4'd8;
  localparam logic [3:0] ST_LAST  = 4'd9;

  // Configuration registers.
  logic [DIM_W-1:0]    grid_width_q, grid_height_q;
  logic [SCALE_W-1:0]  cost_scale_q;
  logic [MARGIN_W-1:0] margin_q;

  // Sequencer and item registers.
  state_e               state_q;
  logic [3:0]           step_q;
  logic [ADDR_W-1:0]    fill_q;
  logic [COST_W-1:0]    cost_q;
  logic [CW-1:0]        wr_x_q, wr_y_q;
  logic [CW-1:0]        lx_q, by_q;
  logic [FRAC_BITS-1:0] ox_q, oy_q;
  logic [COST_W-1:0]    largest_q;
  logic                 rd_in_grid_q;
  logic [MAC_A_W-1:0]   ab_q;
  logic [MAC_SH-1:0]    lo_q;
  logic [RES_W-1:0]     pend_cost_q;
  logic                 pend_inside_q, pend_status_q;

  // Output register.
  logic                 out_valid_q;
  logic [RES_W-1:0]     out_cost_q;
  logic                 out_inside_q, out_status_q;
  logic [COST_W-1:0]    out_max_q;

  logic                 in_xfer, out_load;
  logic [CW-1:0]        eff_w, eff_h;
  logic                 wr_in_grid;
  logic [CW-1:0]        rd_x, rd_y;
  logic                 rd_in_grid;
  logic                 st_we, st_re;
  logic [ADDR_W-1:0]    st_waddr, st_raddr;
  logic [COST_W-1:0]    st_rdata;
  logic [COST_W-1:0]    cell_val;
  mac_ctrl_t            mac_ctrl;
  logic [MAC_A_W-1:0]   mac_a;
  logic [MAC_B_W-1:0]   mac_b;
  logic [ACC_W-1:0]     acc;
  logic [WT_W-1:0]      wx_hi, wy_hi;
  logic [SUM_W-1:0]     rnd_sum;
  logic [RND_W-1:0]     rnd_val;
  logic [RES_W-1:0]     res_sat;

  // Query decode at acceptance.
  logic [FRAC_BITS-1:0] fx, fy;
  logic [CW-1:0]        cx, cy;
  logic signed [MW-1:0] cx_m, cy_m, w_m, h_m, m_m;
  logic                 margin_ok, in_margin;

  function automatic logic in_window(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                     input logic [CW-1:0] w, input logic [CW-1:0] h);
    in_window = !x[CW-1] && !y[CW-1] && (x < w) && (y < h);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] x,
                                                  input logic [CW-1:0] y);
    cell_addr = {y[DIM_BITS-1:0], x[DIM_BITS-1:0]};
  endfunction

  assign in_xfer = in_ch_i.valid && in_ch_i.ready;
  assign in_ch_i.ready = (state_q == S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_height_q <= GRID_HEIGHT_RST;
      cost_scale_q  <= COST_SCALE_RST;
      margin_q      <= MARGIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GRID_WIDTH:   grid_width_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_GRID_HEIGHT:  grid_height_q <= cfg_wdata_i[DIM_W-1:0];
        REG_COST_SCALE:   cost_scale_q  <= cfg_wdata_i[SCALE_W-1:0];
        REG_MARGIN_CELLS: margin_q      <= cfg_wdata_i[MARGIN_W-1:0];
      endcase
    end
  end

  // Window in use, limited to the store size.
  assign eff_w = (CW'(grid_width_q) > DIM_MAX) ? DIM_MAX : CW'(grid_width_q);
  assign eff_h = (CW'(grid_height_q) > DIM_MAX) ? DIM_MAX : CW'(grid_height_q);

  // Split query position into cell and fraction, pick neighbors and margin.
  always_comb begin
    fx   = in_ch_i.pos_x[FRAC_BITS-1:0];
    fy   = in_ch_i.pos_y[FRAC_BITS-1:0];
    cx   = {in_ch_i.pos_x[POS_W-1], in_ch_i.pos_x[POS_W-1:FRAC_BITS]};
    cy   = {in_ch_i.pos_y[POS_W-1], in_ch_i.pos_y[POS_W-1:FRAC_BITS]};
    cx_m = $signed({cx[CW-1], cx});
    cy_m = $signed({cy[CW-1], cy});
    w_m  = $signed({{(MW-DIM_W){1'b0}}, grid_width_q});
    h_m  = $signed({{(MW-DIM_W){1'b0}}, grid_height_q});
    m_m  = $signed({{(MW-MARGIN_W){1'b0}}, margin_q});
    margin_ok = ({1'b0, grid_width_q} >= {1'b0, margin_q, 1'b0});
    in_margin = margin_ok && (cx_m < w_m - m_m) && (cx_m > m_m) &&
                (cy_m < h_m - m_m) && (cy_m > m_m);
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= ST_RD0;
      fill_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            step_q <= ST_RD0;
            fill_q <= '0;
            if (in_ch_i.operation == OP_WRITE) begin
              state_q <= S_WRITE;
            end else if (in_ch_i.operation == OP_FILL) begin
              state_q <= S_FILL;
            end else if (in_ch_i.operation == OP_QUERY) begin
              state_q <= S_QUERY;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_WRITE: state_q <= S_DONE;
        S_FILL: begin
          fill_q <= fill_q + ADDR_W'(1);
          if (fill_q == '1) begin
            state_q <= S_DONE;
          end
        end
        S_QUERY: begin
          step_q <= step_q + 4'd1;
          if (step_q == ST_LAST) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item fields captured at acceptance.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cost_q        <= in_ch_i.cost_value;
      wr_x_q        <= CW'(in_ch_i.cell_x);
      wr_y_q        <= CW'(in_ch_i.cell_y);
      lx_q          <= cx - CW'(1) + CW'(fx[FRAC_BITS-1]);
      by_q          <= cy - CW'(1) + CW'(fy[FRAC_BITS-1]);
      ox_q          <= fx ^ HALF;
      oy_q          <= fy ^ HALF;
      pend_inside_q <= (in_ch_i.operation == OP_QUERY) && in_margin;
      pend_status_q <= 1'b0;
      pend_cost_q   <= '0;
    end else begin
      if (state_q == S_WRITE) begin
        pend_status_q <= !wr_in_grid;
      end
      if (state_q == S_QUERY && step_q == ST_LAST) begin
        pend_cost_q <= res_sat;
      end
    end
  end

  // Running maximum.
  assign wr_in_grid = in_window(wr_x_q, wr_y_q, eff_w, eff_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      largest_q <= '0;
    end else if (state_q == S_FILL) begin
      largest_q <= '0;
    end else if (state_q == S_WRITE && wr_in_grid && cost_q > largest_q) begin
      largest_q <= cost_q;
    end
  end

  // Store access: fill sweep or single write, and the four neighbor reads.
  assign rd_x       = lx_q + CW'(step_q[0]);
  assign rd_y       = by_q + CW'(step_q[1]);
  assign rd_in_grid = in_window(rd_x, rd_y, eff_w, eff_h);
  assign st_re      = (state_q == S_QUERY) && (step_q <= ST_RD3);
  assign st_raddr   = cell_addr(rd_x, rd_y);
  assign st_we      = (state_q == S_FILL) || (state_q == S_WRITE && wr_in_grid);
  assign st_waddr   = (state_q == S_FILL) ? fill_q : cell_addr(wr_x_q, wr_y_q);

  always_ff @(posedge clk_i) begin
    if (st_re) begin
      rd_in_grid_q <= rd_in_grid;
    end
  end

  cgbl_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (COST_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (cost_q),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Cells outside the window read as the running maximum.
  assign cell_val = rd_in_grid_q ? st_rdata : largest_q;
  assign wx_hi    = ONE - WT_W'(ox_q);
  assign wy_hi    = ONE - WT_W'(oy_q);

  // Operand selection for the shared multiply-accumulate unit.
  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    if (state_q == S_QUERY) begin
      unique case (step_q)
        ST_RD1: begin
          mac_ctrl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
          mac_a    = MAC_A_W'(cell_val);
          mac_b    = MAC_B_W'(wx_hi);
        end
        ST_RD2, ST_ROW1: begin
          mac_ctrl = '{en: 1'b1, clr: 1'b0, shift: 1'b0};
          mac_a    = MAC_A_W'(cell_val);
          mac_b    = MAC_B_W'(ox_q);
        end
        ST_RD3: begin
          mac_ctrl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
          mac_a    = MAC_A_W'(cell_val);
          mac_b    = MAC_B_W'(wx_hi);
        end
        ST_COL0: begin
          mac_ctrl = '{en: 1'b1, clr: 1'b1, shift: 1'b0};
          mac_a    = acc[MAC_A_W-1:0];
          mac_b    = MAC_B_W'(oy_q);
        end
        ST_COL1: begin
          mac_ctrl = '{en: 1'b1, clr: 1'b0, shift: 1'b0};
          mac_a    = ab_q;
          mac_b    = MAC_B_W'(wy_hi);
        end
        ST_SCLH: begin
          mac_ctrl = '{en: 1'b1, clr: 1'b1, shift: 1'b1};
          mac_a    = MAC_A_W'(acc[MAC_SH +: COST_W]);
          mac_b    = cost_scale_q;
        end
        ST_SCLL: begin
          mac_ctrl = '{en: 1'b1, clr: 1'b0, shift: 1'b0};
          mac_a    = MAC_A_W'(lo_q);
          mac_b    = cost_scale_q;
        end
        default: begin
          mac_ctrl = '0;
        end
      endcase
    end
  end

  // Partial results kept across steps: bottom row sum and low fraction part.
  always_ff @(posedge clk_i) begin
    if (state_q == S_QUERY && step_q == ST_RD3) begin
      ab_q <= acc[MAC_A_W-1:0];
    end
    if (state_q == S_QUERY && step_q == ST_SCLH) begin
      lo_q <= acc[MAC_SH-1:0];
    end
  end

  cgbl_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // Round half up to the output fraction and saturate.
  always_comb begin
    rnd_sum = SUM_W'(acc) + RND_BIAS;
    rnd_val = rnd_sum[SUM_W-1:RND_SH];
    res_sat = (|rnd_val[RND_W-1:RES_W]) ? '1 : rnd_val[RES_W-1:0];
  end

  // Output register: loads when empty or when its result is taken.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cost_q   <= pend_cost_q;
      out_inside_q <= pend_inside_q;
      out_status_q <= pend_status_q;
      out_max_q    <= largest_q;
    end
  end

  assign out_ch_o.valid         = out_valid_q;
  assign out_ch_o.cost_to_go    = out_cost_q;
  assign out_ch_o.inside_margin = out_inside_q;
  assign out_ch_o.max_cost      = out_max_q;
  assign out_ch_o.status        = out_status_q;

`ifndef SYNTHESIS
  // An accepted query starts the interpolation sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_ch_i.operation == OP_QUERY) |=> (state_q == S_QUERY && step_q == ST_RD0))
    else $error("query did not start the read sequence");

  // The step counter never runs past the last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QUERY) |-> (step_q <= ST_LAST))
    else $error("query step counter overran");

  // A fill leaves the maximum cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |=> (largest_q == '0))
    else $error("fill did not clear the maximum");

  // A rejected write leaves the maximum unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && !wr_in_grid) |=> $stable(largest_q))
    else $error("rejected write changed the maximum");

  // The output register is loaded only from the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q)) |-> ($past(state_q) == S_DONE))
    else $error("result presented outside the result state");
`endif

endmodule

>>> tb/cgbl_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cost grid bilinear lookup: result checker
// Follows every transfer on the input and result channels and every register
// write. Keeps its own copy of the grid, the running maximum and the
// registers, predicts the result of each accepted operation, and compares
// each returned result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cgbl_result_checker import cgbl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cgbl_in_if                    in_mon_i,
  cgbl_out_if                   out_mon_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int ONE_Q  = 1 << FRAC_BITS;
  localparam int HALF_Q = ONE_Q / 2;
  localparam int PROD_SH = 2 * FRAC_BITS;

  typedef struct packed {
    logic [RES_W-1:0]  cost_to_go;
    logic              inside_margin;
    logic [COST_W-1:0] max_cost;
    logic              status;
  } grid_reply_t;

  // Cells written since the last fill; every other cell holds the fill cost.
  logic [COST_W-1:0]   written_cells [int];
  logic [COST_W-1:0]   fill_cost;
  logic [COST_W-1:0]   peak_cost;
  logic [DIM_W-1:0]    width_q;
  logic [DIM_W-1:0]    height_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [MARGIN_W-1:0] margin_q;
  grid_reply_t         reply_q [$];
  grid_reply_t         want;

  // A window size beyond the store acts as the full store.
  function automatic int clip_dim(logic [DIM_W-1:0] d);
    return (d > MAX_DIM_DEF) ? int'(MAX_DIM_DEF) : int'(d);
  endfunction

  // Cells outside the window in use read as the running maximum.
  function automatic longint unsigned cell_cost(int x, int y);
    int idx;
    if (x < 0 || y < 0 || x >= clip_dim(width_q) || y >= clip_dim(height_q))
      return peak_cost;
    idx = y * int'(MAX_DIM_DEF) + x;
    return written_cells.exists(idx) ? written_cells[idx] : fill_cost;
  endfunction

  // Applies one operation to the grid copy and returns its result.
  function automatic grid_reply_t apply_grid_op(
    logic [OP_W-1:0]         op,
    logic [COORD_W-1:0]      cx,
    logic [COORD_W-1:0]      cy,
    logic [COST_W-1:0]       cost,
    logic signed [POS_W-1:0] px,
    logic signed [POS_W-1:0] py
  );
    grid_reply_t          rep;
    int                   col, row, left, bottom, w, h, m;
    logic [FRAC_BITS-1:0] fx, fy;
    longint unsigned      ox, oy, ab, at, ay, whole, part, hi, lo, total;
    rep = '0;
    case (op)
      OP_WRITE: begin
        if (int'(cx) >= clip_dim(width_q) || int'(cy) >= clip_dim(height_q)) begin
          rep.status = 1'b1;
        end else begin
          written_cells[int'(cy) * int'(MAX_DIM_DEF) + int'(cx)] = cost;
          if (cost > peak_cost) peak_cost = cost;
        end
      end
      OP_FILL: begin
        written_cells.delete();
        fill_cost = cost;
        peak_cost = '0;
      end
      OP_QUERY: begin
        // Floor of the position, then the centre-offset neighbor choice.
        col = int'(px) >>> FRAC_BITS;
        row = int'(py) >>> FRAC_BITS;
        fx = px[FRAC_BITS-1:0];
        fy = py[FRAC_BITS-1:0];
        left   = col - 1 + ((fx >= HALF_Q) ? 1 : 0);
        bottom = row - 1 + ((fy >= HALF_Q) ? 1 : 0);
        ox = (fx < HALF_Q) ? fx + HALF_Q : fx - HALF_Q;
        oy = (fy < HALF_Q) ? fy + HALF_Q : fy - HALF_Q;

        // Exact bilinear blend in units of 2^-(2*FRAC_BITS) cost.
        ab = cell_cost(left, bottom) * (ONE_Q - ox) + cell_cost(left + 1, bottom) * ox;
        at = cell_cost(left, bottom + 1) * (ONE_Q - ox)
           + cell_cost(left + 1, bottom + 1) * ox;
        ay = ab * (ONE_Q - oy) + at * oy;

        // Scale to metres and round half up to the output fraction.
        whole = ay >> PROD_SH;
        part  = ay & ((64'd1 << PROD_SH) - 1);
        hi = whole * scale_q;
        lo = part * scale_q;
        total = (hi >> OUT_FRAC)
              + ((((hi & ((64'd1 << OUT_FRAC) - 1)) << PROD_SH) + lo
                 + (64'd1 << (PROD_SH + OUT_FRAC - 1))) >> (PROD_SH + OUT_FRAC));
        rep.cost_to_go = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[RES_W-1:0];

        // Margin test on the raw register values.
        w = int'(width_q);
        h = int'(height_q);
        m = int'(margin_q);
        if (w >= 2 * m)
          rep.inside_margin = (col < w - m) && (col > m) && (row < h - m) && (row > m);
      end
      default: ;
    endcase
    rep.max_cost = peak_cost;
    return rep;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Results are retired before new operations are queued at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_cells.delete();
      reply_q.delete();
      fill_cost    = '0;
      peak_cost    = '0;
      width_q      = GRID_WIDTH_RST;
      height_q     = GRID_HEIGHT_RST;
      scale_q      = COST_SCALE_RST;
      margin_q     = MARGIN_RST;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %0h/%0b/%0h/%0b",
                   $time, out_mon_i.cost_to_go, out_mon_i.inside_margin,
                   out_mon_i.max_cost, out_mon_i.status);
          fail_count_o++;
        end else begin
          want = reply_q.pop_front();
          check_field("cost_to_go", want.cost_to_go, out_mon_i.cost_to_go);
          check_field("inside_margin", want.inside_margin, out_mon_i.inside_margin);
          check_field("max_cost", want.max_cost, out_mon_i.max_cost);
          check_field("status", want.status, out_mon_i.status);
        end
      end

      if (in_mon_i.valid && in_mon_i.ready)
        reply_q.push_back(apply_grid_op(in_mon_i.operation, in_mon_i.cell_x,
                                        in_mon_i.cell_y, in_mon_i.cost_value,
                                        in_mon_i.pos_x, in_mon_i.pos_y));

      // Register writes are to be made only while the block is idle; the checker does not enforce this.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_WIDTH:   width_q  = cfg_wdata_i[DIM_W-1:0];
          REG_GRID_HEIGHT:  height_q = cfg_wdata_i[DIM_W-1:0];
          REG_COST_SCALE:   scale_q  = cfg_wdata_i[SCALE_W-1:0];
          REG_MARGIN_CELLS: margin_q = cfg_wdata_i[MARGIN_W-1:0];
          default: ;
        endcase
      end

      pending_o = reply_q.size();
    end
  end

endmodule

>>> tb/tb_cost_grid_bilinear_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cost grid bilinear lookup: testbench top
// Drives a directed set of writes, fills and queries, then random operations
// over nine register settings with stalls on both channels, and a long
// result hold-off that backs the block up. The result checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_cost_grid_bilinear_lookup_top;
  import cgbl_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int HOLD_CYCLES      = 300;
  localparam int SETTLE_CYCLES    = 20;
  localparam int STALL_LIMIT      = 262144;
  localparam int ITEMS_PER_PHASE  = 158;
  localparam int RANDOM_PHASES    = 9;
  localparam int MAX_RANDOM_FILLS = 4;
  localparam int CELL_Q           = 1 << FRAC_BITS;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  bit                    hold_req;
  int                    items_sent;
  int                    fills_left;
  int                    idle_cycles = 0;
  int                    grid_cols;
  int                    grid_rows;

  cgbl_in_if  in_ch ();
  cgbl_out_if out_ch ();

  cost_grid_bilinear_lookup_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch_i     (in_ch),
    .out_ch_o    (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  cgbl_result_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // The run ends if no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Offers one operation and holds it until the transfer; called and
  // returning at a falling edge. Random gaps follow the transfer.
  task automatic send_op(
    input logic [OP_W-1:0]         op,
    input logic [COORD_W-1:0]      cx,
    input logic [COORD_W-1:0]      cy,
    input logic [COST_W-1:0]       cost,
    input logic signed [POS_W-1:0] px,
    input logic signed [POS_W-1:0] py
  );
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.cell_x     <= cx;
    in_ch.cell_y     <= cy;
    in_ch.cost_value <= cost;
    in_ch.pos_x      <= px;
    in_ch.pos_y      <= py;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
  endtask

  // Waits until every result has come back and the block is idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes all four registers back to back; only while idle.
  task automatic write_regs(input int w, input int h, input int s, input int m);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_GRID_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w);
    @(negedge clk_i);
    cfg_idx   <= REG_GRID_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h);
    @(negedge clk_i);
    cfg_idx   <= REG_COST_SCALE;
    cfg_wdata <= CFG_DATA_W'(s);
    @(negedge clk_i);
    cfg_idx   <= REG_MARGIN_CELLS;
    cfg_wdata <= CFG_DATA_W'(m);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    grid_cols = (w > int'(MAX_DIM_DEF)) ? int'(MAX_DIM_DEF) : w;
    grid_rows = (h > int'(MAX_DIM_DEF)) ? int'(MAX_DIM_DEF) : h;
  endtask

  task automatic apply_phase(input int p);
    case (p)
      0: write_regs(256, 256, 65535, 0);
      1: write_regs(1, 1, 0, 0);
      2: write_regs(16, 9, 32768, 3);
      3: write_regs(256, 1, 1, 255);
      4: write_regs(8, 8, 65535, 2);
      5: write_regs(1, 256, 12345, 128);
      6: write_regs(511, 0, 40000, 0);
      7: write_regs($urandom_range(1, 256), $urandom_range(1, 256),
                    $urandom_range(65535), $urandom_range(20));
      default: write_regs(256, 256, 65535, 127);
    endcase
  endtask

  // Costs lean towards the extremes now and then.
  function automatic logic [COST_W-1:0] rand_cost();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return COST_W'($urandom_range(255));
      default: return COST_W'($urandom);
    endcase
  endfunction

  // Position anywhere in the window or up to two cells past either edge, random fraction.
  function automatic int near_grid_pos(input int dim);
    return (int'($urandom_range(dim + 3)) - 2) * CELL_Q + int'($urandom_range(CELL_Q - 1));
  endfunction

  task automatic send_random_item();
    int                      pick;
    logic [OP_W-1:0]         op;
    logic [COORD_W-1:0]      x, y;
    logic signed [POS_W-1:0] px, py;
    op = OP_QUERY;
    x  = COORD_W'($urandom);
    y  = COORD_W'($urandom);
    px = POS_W'($urandom);
    py = POS_W'($urandom);
    pick = $urandom_range(999);
    if (pick < 4 && fills_left > 0) begin
      op = OP_FILL;
      fills_left--;
    end else if (pick < 30) begin
      op = OP_SPARE;
    end else if (pick < 430) begin
      op = OP_WRITE;
      if (grid_cols > 0 && grid_rows > 0 && $urandom_range(9) != 0) begin
        x = COORD_W'($urandom_range(grid_cols - 1));
        y = COORD_W'($urandom_range(grid_rows - 1));
      end
    end else if ($urandom_range(9) != 0) begin
      px = POS_W'(near_grid_pos(grid_cols));
      py = POS_W'(near_grid_pos(grid_rows));
    end
    send_op(op, x, y, rand_cost(), px, py);
  endtask

  initial begin : stimulus
    int p;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_GRID_WIDTH;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_WRITE;
    in_ch.cell_x     = '0;
    in_ch.cell_y     = '0;
    in_ch.cost_value = '0;
    in_ch.pos_x      = '0;
    in_ch.pos_y      = '0;
    send_idle_pct    = 26;
    recv_idle_pct    = 80;
    hold_req         = 1'b0;
    items_sent       = 0;
    fills_left       = MAX_RANDOM_FILLS;
    grid_cols        = MAX_DIM_DEF;
    grid_rows        = MAX_DIM_DEF;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Full grid: a fill first so that no cell is read before it is set,
    // writes at the corners, queries at the edges and position extremes.
    send_op(OP_FILL, 0, 0, 1000, 0, 0);
    send_op(OP_WRITE, 0, 0, 24'hFF_FFFF, 0, 0);
    send_op(OP_WRITE, 255, 255, 0, 0, 0);
    send_op(OP_WRITE, 255, 0, 24'h12_3456, 0, 0);
    send_op(OP_WRITE, 0, 255, 24'hAB_CDEF, 0, 0);
    send_op(OP_WRITE, 128, 77, 1, 0, 0);
    send_op(OP_QUERY, 0, 0, 0, 0, 0);
    send_op(OP_QUERY, 0, 0, 0, 131071, 131071);
    send_op(OP_QUERY, 0, 0, 0, -131072, -131072);
    send_op(OP_QUERY, 0, 0, 0, 128 * CELL_Q + CELL_Q / 2, 77 * CELL_Q + CELL_Q / 2 - 1);
    send_op(OP_QUERY, 0, 0, 0, 256 * CELL_Q - 1, 255 * CELL_Q + CELL_Q / 2);
    send_op(OP_QUERY, 0, 0, 0, 128 * CELL_Q, 77 * CELL_Q);
    send_op(OP_SPARE, '1, '1, '1, -1, -1);
    // Largest costs everywhere with the largest scale.
    send_op(OP_FILL, 0, 0, 24'hFF_FFFF, 0, 0);
    send_op(OP_QUERY, 0, 0, 0, 100 * CELL_Q + 77, 100 * CELL_Q + 179);

    // Small window: writes outside it are refused, margin of one cell.
    settle();
    write_regs(5, 4, 16'h8000, 1);
    send_op(OP_WRITE, 5, 0, 24'h00_0300, 0, 0);
    send_op(OP_WRITE, 0, 4, 24'h00_0400, 0, 0);
    send_op(OP_WRITE, 4, 2, 24'h00_0200, 0, 0);
    send_op(OP_WRITE, 1, 1, 24'h7F_FFFF, 0, 0);
    send_op(OP_QUERY, 0, 0, 0, 2 * CELL_Q + CELL_Q / 2, 2 * CELL_Q + CELL_Q / 2);
    send_op(OP_QUERY, 0, 0, 0, 5 * CELL_Q - 26, 4 * CELL_Q - 26);
    send_op(OP_QUERY, 0, 0, 0, -CELL_Q / 2, -CELL_Q / 2);

    // Random operations over a range of register settings.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      apply_phase(p);
      if (p == 0) hold_req = 1'b1;
      if (p == 3) begin
        send_idle_pct = 80;
        recv_idle_pct = 26;
      end
      if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (ITEMS_PER_PHASE) send_random_item();
    end
    settle();

    $display("Sent %0d operations: writes inside and outside the window, fills, queries",
             items_sent);
    $display("on and off the grid and spare codes, over ten register settings with stalls.");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
